>>> src/vir_pkg.sv
// Shared types and constants for the VARMA impulse-response generator.
// Used by every module of the block; has no dependencies of its own.
package vir_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int MAX_AR_DEF    = 8;
	localparam int MAX_MA_DEF    = 8;
	localparam int LAG_LIMIT_DEF = 1023;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		OP_WR_AR   = 2'd0,
		OP_WR_MA   = 2'd1,
		OP_EMIT    = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_AR_ORDER = 2'd0,
		REG_MA_ORDER = 2'd1,
		REG_DIM      = 2'd2,
		REG_MAX_LAG  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t                opcode;
		logic [3:0]         coef_lag;
		logic [2:0]         coef_row;
		logic [2:0]         coef_col;
		logic signed [31:0] coef_value;
	} req_t;

	typedef struct packed {
		logic [9:0]         out_lag;
		logic [2:0]         out_row;
		logic [2:0]         out_col;
		logic signed [31:0] out_value;
		logic               last_of_lag;
		logic               saturated;
	} rsp_t;

	typedef struct packed {
		logic [3:0] ar_order;
		logic [3:0] ma_order;
		logic [3:0] dim;
		logic [9:0] max_lag;
	} cfg_t;

	typedef struct packed {
		logic               vld;
		logic               first;
		logic               last;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} mac_in_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] value;
		logic               sat;
	} mac_res_t;

endpackage

>>> src/vir_regs.sv
// APB register bank: order, dimension and lag limit registers.
// Depends on vir_pkg for cfg_t and register indexes.
module vir_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vir_pkg::APB_AW-1:0] paddr,
	input  logic [vir_pkg::APB_DW-1:0] pwdata,
	output logic [vir_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output vir_pkg::cfg_t              cfg
);
	import vir_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ar_order <= 4'd0;
			cfg_q.ma_order <= 4'd0;
			cfg_q.dim      <= 4'd1;
			cfg_q.max_lag  <= 10'd0;
		end else if (wr_en) begin
			case (idx)
				REG_AR_ORDER: cfg_q.ar_order <= pwdata[3:0];
				REG_MA_ORDER: cfg_q.ma_order <= pwdata[3:0];
				REG_DIM:      cfg_q.dim      <= pwdata[3:0];
				REG_MAX_LAG:  cfg_q.max_lag  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_AR_ORDER: prdata[3:0] = cfg_q.ar_order;
			REG_MA_ORDER: prdata[3:0] = cfg_q.ma_order;
			REG_DIM:      prdata[3:0] = cfg_q.dim;
			REG_MAX_LAG:  prdata[9:0] = cfg_q.max_lag;
			default:      prdata      = '0;
		endcase
	end

endmodule

>>> src/vir_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, Q.24 accumulate,
// round to Q16.16 and saturate. Depends on vir_pkg for mac_in_t and mac_res_t.
module vir_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  vir_pkg::mac_in_t  mi,
	output vir_pkg::mac_res_t mres
);
	import vir_pkg::*;

	logic signed [63:0] prod_s2;
	logic               vld_s2;
	logic               first_s2;
	logic               last_s2;
	logic signed [63:0] acc_q;
	logic               done_q;
	logic signed [63:0] term;
	logic signed [63:0] rnd;
	logic               sat_hi;
	logic               sat_lo;

	assign term = prod_s2 >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s2 <= mi.vld;
			done_q <= vld_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2  <= 64'(mi.a) * 64'(mi.b);
		first_s2 <= mi.first;
		last_s2  <= mi.last;
		if (vld_s2) begin
			acc_q <= first_s2 ? term : acc_q + term;
		end
	end

	always_comb begin
		rnd    = (acc_q + 64'sd128) >>> 8;
		sat_hi = rnd > 64'(Q16_MAX);
		sat_lo = rnd < 64'(Q16_MIN);
		mres.done  = done_q;
		mres.sat   = sat_hi || sat_lo;
		mres.value = sat_hi ? Q16_MAX : (sat_lo ? Q16_MIN : rnd[31:0]);
	end

endmodule

>>> src/vir_core.sv
// Lag sequencer: coefficient and history memories, term issue into the
// shared MAC, output word register. Depends on vir_pkg and vir_mac.
module vir_core #(
	parameter int MAX_DIM   = vir_pkg::MAX_DIM_DEF,
	parameter int MAX_AR    = vir_pkg::MAX_AR_DEF,
	parameter int MAX_MA    = vir_pkg::MAX_MA_DEF,
	parameter int LAG_LIMIT = vir_pkg::LAG_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  vir_pkg::cfg_t cfg,
	input  logic          req_valid,
	output logic          req_stall,
	input  vir_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output vir_pkg::rsp_t rsp
);
	import vir_pkg::*;

	localparam int MSIZE = MAX_DIM * MAX_DIM;
	localparam int NSLOT = MAX_AR + 1;
	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int PW    = $clog2(MAX_AR + 1);
	localparam int QW    = $clog2(MAX_MA + 1);
	localparam int SW    = $clog2(NSLOT);
	localparam int LW    = $clog2(LAG_LIMIT + 2);
	localparam int ARW   = (MAX_AR * MSIZE > 1) ? $clog2(MAX_AR * MSIZE) : 1;
	localparam int MAW   = (MAX_MA * MSIZE > 1) ? $clog2(MAX_MA * MSIZE) : 1;
	localparam int HW    = $clog2(NSLOT * MSIZE);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ELEM = 5'b00010,
		S_TERM = 5'b00100,
		S_WAIT = 5'b01000,
		S_PUT  = 5'b10000
	} state_t;

	state_t  state_q;
	logic [IW-1:0] r_q, c_q, k_q;
	logic [PW-1:0] i_q;
	logic [LW-1:0] lag_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] src_slot;

	logic signed [31:0] ar_mem   [MAX_AR*MSIZE];
	logic signed [31:0] ma_mem   [MAX_MA*MSIZE];
	logic signed [31:0] hist_mem [NSLOT*MSIZE];

	logic signed [31:0] ar_rd_s1, ma_rd_s1, hist_rd_s1;
	logic tok_vld_s1, tok_first_s1, tok_last_s1, ma_use_s1, ident_s1;

	logic [DW-1:0] d_eff;
	logic [PW-1:0] p_eff, pmax;
	logic [QW-1:0] q_eff;
	logic [LW-1:0] ml;
	logic          ma_use, ident, in_dim, k_end, i_end, cell_last, out_free;
	logic          acc_fire, put_fire, tok_issue, tok_last;
	logic          ar_we, ma_we, hist_we;
	logic [ARW-1:0] ar_waddr, ar_raddr;
	logic [MAW-1:0] ma_waddr, ma_raddr;
	logic [HW-1:0]  hist_waddr, hist_raddr;
	logic signed [31:0] hist_wdata;

	rsp_t     rsp_q;
	logic     rsp_valid_q;
	mac_in_t  mi;
	mac_res_t mres;

	vir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.mi     (mi),
		.mres   (mres)
	);

	always_comb begin
		d_eff = (cfg.dim == 4'd0) ? DW'(1) :
			((int'(cfg.dim) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg.dim));
		p_eff = (int'(cfg.ar_order) > MAX_AR) ? PW'(MAX_AR) : PW'(cfg.ar_order);
		q_eff = (int'(cfg.ma_order) > MAX_MA) ? QW'(MAX_MA) : QW'(cfg.ma_order);
		ml    = (int'(cfg.max_lag) > LAG_LIMIT) ? LW'(LAG_LIMIT) : LW'(cfg.max_lag);
		pmax  = (int'(lag_q) < int'(p_eff)) ? PW'(lag_q) : p_eff;
		ma_use = (lag_q != '0) && (int'(lag_q) <= int'(q_eff));
		ident  = (lag_q == '0) && (r_q == c_q);
		in_dim = (int'(r_q) < int'(d_eff)) && (int'(c_q) < int'(d_eff));
		k_end  = int'(k_q) == int'(d_eff) - 1;
		i_end  = i_q == pmax;
		cell_last = (int'(r_q) == MAX_DIM - 1) && (int'(c_q) == MAX_DIM - 1);
		src_slot = (int'(slot_q) >= int'(i_q)) ? SW'(int'(slot_q) - int'(i_q)) :
			SW'(int'(slot_q) + NSLOT - int'(i_q));
	end

	assign req_stall = state_q != S_IDLE;
	assign acc_fire  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign put_fire  = (state_q == S_PUT) && out_free;
	assign tok_issue = ((state_q == S_ELEM) && in_dim) || (state_q == S_TERM);
	assign tok_last  = (state_q == S_ELEM) ? (pmax == '0) : (i_end && k_end);

	assign ar_we = acc_fire && (req.opcode == OP_WR_AR) && (req.coef_lag != 4'd0) &&
		(int'(req.coef_lag) <= MAX_AR) && (int'(req.coef_row) < MAX_DIM) &&
		(int'(req.coef_col) < MAX_DIM);
	assign ma_we = acc_fire && (req.opcode == OP_WR_MA) && (req.coef_lag != 4'd0) &&
		(int'(req.coef_lag) <= MAX_MA) && (int'(req.coef_row) < MAX_DIM) &&
		(int'(req.coef_col) < MAX_DIM);
	assign ar_waddr = ARW'((int'(req.coef_lag) - 1) * MSIZE +
		int'(req.coef_row) * MAX_DIM + int'(req.coef_col));
	assign ma_waddr = MAW'((int'(req.coef_lag) - 1) * MSIZE +
		int'(req.coef_row) * MAX_DIM + int'(req.coef_col));
	assign ar_raddr = ARW'((int'(i_q) - 1) * MSIZE + int'(r_q) * MAX_DIM + int'(k_q));
	assign ma_raddr = MAW'((int'(lag_q) - 1) * MSIZE + int'(r_q) * MAX_DIM + int'(c_q));
	assign hist_raddr = HW'(int'(src_slot) * MSIZE + int'(k_q) * MAX_DIM + int'(c_q));
	assign hist_waddr = HW'(int'(slot_q) * MSIZE + int'(r_q) * MAX_DIM + int'(c_q));
	assign hist_we    = ((state_q == S_ELEM) && !in_dim) || put_fire;
	assign hist_wdata = put_fire ? mres.value : '0;

	always_ff @(posedge clk) begin
		if (ar_we) ar_mem[ar_waddr] <= req.coef_value;
		ar_rd_s1 <= ar_mem[ar_raddr];
	end

	always_ff @(posedge clk) begin
		if (ma_we) ma_mem[ma_waddr] <= req.coef_value;
		ma_rd_s1 <= ma_mem[ma_raddr];
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		hist_rd_s1 <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		tok_first_s1 <= state_q == S_ELEM;
		tok_last_s1  <= tok_last;
		ma_use_s1    <= ma_use;
		ident_s1     <= ident;
	end

	always_comb begin
		mi.vld   = tok_vld_s1;
		mi.first = tok_first_s1;
		mi.last  = tok_last_s1;
		mi.a     = tok_first_s1 ? (ma_use_s1 ? ma_rd_s1 : (ident_s1 ? ONE_Q16 : '0)) :
			ar_rd_s1;
		mi.b     = tok_first_s1 ? ONE_Q16 : hist_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			lag_q       <= '0;
			slot_q      <= '0;
			tok_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			tok_vld_s1 <= tok_issue;
			if (put_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_fire) begin
						case (req.opcode)
							OP_EMIT: begin
								if (lag_q <= ml) begin
									r_q     <= '0;
									c_q     <= '0;
									state_q <= S_ELEM;
								end
							end
							OP_RESTART: begin
								lag_q  <= '0;
								slot_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_ELEM: begin
					if (in_dim) begin
						i_q     <= PW'(1);
						k_q     <= '0;
						state_q <= (pmax == '0) ? S_WAIT : S_TERM;
					end
				end
				S_TERM: begin
					if (k_end) begin
						k_q <= '0;
						i_q <= i_q + 1'b1;
						if (i_end) state_q <= S_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (mres.done) state_q <= S_PUT;
				end
				S_PUT: ;
				default: state_q <= S_IDLE;
			endcase
			// advance to the next cell once this one is written
			if (((state_q == S_ELEM) && !in_dim) || put_fire) begin
				if (int'(c_q) == MAX_DIM - 1) begin
					c_q <= '0;
					if (cell_last) begin
						r_q     <= '0;
						lag_q   <= lag_q + 1'b1;
						slot_q  <= (int'(slot_q) == NSLOT - 1) ? '0 : slot_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_ELEM;
					end
				end else begin
					c_q     <= c_q + 1'b1;
					state_q <= S_ELEM;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (put_fire) begin
			rsp_q.out_lag     <= 10'(lag_q);
			rsp_q.out_row     <= 3'(r_q);
			rsp_q.out_col     <= 3'(c_q);
			rsp_q.out_value   <= mres.value;
			rsp_q.last_of_lag <= (int'(r_q) == int'(d_eff) - 1) &&
				(int'(c_q) == int'(d_eff) - 1);
			rsp_q.saturated   <= mres.sat;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mres.done |-> state_q == S_WAIT)
		else $error("MAC result arrived outside the wait state");

	a_put_shows: assert property (@(posedge clk) disable iff (!arst_n)
		put_fire |=> rsp_valid)
		else $error("finished element not presented as a word");

	a_src_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TERM) |-> src_slot != slot_q)
		else $error("history read collides with the slot being written");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SW'(NSLOT - 1))
		else $error("history slot pointer out of range");

endmodule

>>> src/varma_impulse_response_top.sv
// Top level of the VARMA impulse-response generator: APB registers and core.
// Depends on vir_pkg, vir_regs and vir_core.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   vir_pkg::req_t
//   rsp      out        rsp_valid / rsp_stall   vir_pkg::rsp_t
//   apb      in         psel / penable / pready paddr, pwdata, prdata
//
// Coefficient write and restart words leave the sequencer idle, so req_stall stays low.
// An emit word computes d^2 elements, each from a seed term and p'*d products, p' = min(ar_order, lag),
// issued through the single shared multiplier at one product per cycle.
// req_stall is high from an emit word within max_lag until its last cell is written to history.
// A stalled rsp word holds the sequencer at that element; the next word is accepted
// while the final word of a lag still waits. Reset clears state but not the memories.
module varma_impulse_response_top #(
	parameter int MAX_DIM   = vir_pkg::MAX_DIM_DEF,
	parameter int MAX_AR    = vir_pkg::MAX_AR_DEF,
	parameter int MAX_MA    = vir_pkg::MAX_MA_DEF,
	parameter int LAG_LIMIT = vir_pkg::LAG_LIMIT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  vir_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output vir_pkg::rsp_t              rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vir_pkg::APB_AW-1:0] paddr,
	input  logic [vir_pkg::APB_DW-1:0] pwdata,
	output logic [vir_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import vir_pkg::*;

	cfg_t cfg;

	vir_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vir_core #(
		.MAX_DIM   (MAX_DIM),
		.MAX_AR    (MAX_AR),
		.MAX_MA    (MAX_MA),
		.LAG_LIMIT (LAG_LIMIT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for varma_impulse_response_top: loads coefficient matrices, emits
// response lags and checks every element against an in-bench recursion predictor.
// Depends on vir_pkg and the varma_impulse_response_top RTL only.
module testbench;
	import vir_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int MSIZE = MAX_DIM_DEF * MAX_DIM_DEF;
	localparam int NSLOT = MAX_AR_DEF + 1;

	class psi_scoreboard;
		int ar_coef [MAX_AR_DEF * MSIZE];
		int ma_coef [MAX_MA_DEF * MSIZE];
		int psi_hist [NSLOT * MSIZE];
		int next_lag;
		int ar_order, ma_order, dim, max_lag;
		rsp_t psi_due [$];
		int errors, checked, lags_done;

		function new();
			foreach (ar_coef[n]) ar_coef[n] = 0;
			foreach (ma_coef[n]) ma_coef[n] = 0;
			foreach (psi_hist[n]) psi_hist[n] = 0;
			next_lag = 0;
			ar_order = 0;
			ma_order = 0;
			dim = 1;
			max_lag = 0;
			errors = 0;
			checked = 0;
			lags_done = 0;
		endfunction

		function int pending();
			return psi_due.size();
		endfunction

		function void set_reg(reg_idx_t idx, int value);
			case (idx)
			REG_AR_ORDER: ar_order = value;
			REG_MA_ORDER: ma_order = value;
			REG_DIM:      dim = value;
			REG_MAX_LAG:  max_lag = value;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("ERROR: %s", msg);
		endtask

		function void note_word(req_t w);
			int r, c, i, k, slot, pmax, src, idx, lim;
			longint acc, res;
			int v;
			bit sat;
			rsp_t e;
			case (w.opcode)
			OP_WR_AR, OP_WR_MA: begin
				lim = (w.opcode == OP_WR_AR) ? MAX_AR_DEF : MAX_MA_DEF;
				if (w.coef_lag != 0 && int'(w.coef_lag) <= lim) begin
					idx = (int'(w.coef_lag) - 1) * MSIZE + int'(w.coef_row) * MAX_DIM_DEF
						+ int'(w.coef_col);
					if (w.opcode == OP_WR_AR)
						ar_coef[idx] = w.coef_value;
					else
						ma_coef[idx] = w.coef_value;
				end
			end
			OP_RESTART: next_lag = 0;
			OP_EMIT: begin
				if (next_lag <= max_lag) begin
					slot = next_lag % NSLOT;
					pmax = (ar_order < next_lag) ? ar_order : next_lag;
					for (r = 0; r < MAX_DIM_DEF; r++) begin
						for (c = 0; c < MAX_DIM_DEF; c++) begin
							v = 0;
							sat = 1'b0;
							if (r < dim && c < dim) begin
								if (next_lag == 0) begin
									v = (r == c) ? ONE_Q16 : 0;
								end else begin
									acc = 0;
									if (next_lag <= ma_order)
										acc = longint'(ma_coef[(next_lag - 1) * MSIZE
											+ r * MAX_DIM_DEF + c]) <<< 8;
									for (i = 1; i <= pmax; i++) begin
										src = ((next_lag - i) % NSLOT) * MSIZE;
										for (k = 0; k < dim; k++)
											acc += (longint'(ar_coef[(i - 1) * MSIZE
												+ r * MAX_DIM_DEF + k])
												* longint'(psi_hist[src + k * MAX_DIM_DEF + c]))
												>>> 8;
									end
									res = (acc + 128) >>> 8;
									if (res > longint'(Q16_MAX)) begin
										res = longint'(Q16_MAX);
										sat = 1'b1;
									end else if (res < longint'(Q16_MIN)) begin
										res = longint'(Q16_MIN);
										sat = 1'b1;
									end
									v = int'(res);
								end
								e.out_lag = next_lag[9:0];
								e.out_row = r[2:0];
								e.out_col = c[2:0];
								e.out_value = v;
								e.last_of_lag = (r == dim - 1 && c == dim - 1);
								e.saturated = sat;
								psi_due.push_back(e);
							end
							psi_hist[slot * MSIZE + r * MAX_DIM_DEF + c] = v;
						end
					end
					next_lag++;
					lags_done++;
				end
			end
			endcase
		endfunction

		task check_word(rsp_t got);
			rsp_t want;
			if (psi_due.size() == 0) begin
				report($sformatf("unexpected word: lag %0d row %0d col %0d value %h",
					got.out_lag, got.out_row, got.out_col, got.out_value));
				return;
			end
			want = psi_due.pop_front();
			checked++;
			if (got.out_lag !== want.out_lag)
				report($sformatf("lag: got %0d want %0d", got.out_lag, want.out_lag));
			if (got.out_row !== want.out_row)
				report($sformatf("lag %0d row: got %0d want %0d", want.out_lag,
					got.out_row, want.out_row));
			if (got.out_col !== want.out_col)
				report($sformatf("lag %0d col: got %0d want %0d", want.out_lag,
					got.out_col, want.out_col));
			if (got.out_value !== want.out_value)
				report($sformatf("lag %0d (%0d,%0d) value: got %h want %h", want.out_lag,
					want.out_row, want.out_col, got.out_value, want.out_value));
			if (got.last_of_lag !== want.last_of_lag)
				report($sformatf("lag %0d (%0d,%0d) last: got %b want %b", want.out_lag,
					want.out_row, want.out_col, got.last_of_lag, want.last_of_lag));
			if (got.saturated !== want.saturated)
				report($sformatf("lag %0d (%0d,%0d) saturated: got %b want %b", want.out_lag,
					want.out_row, want.out_col, got.saturated, want.saturated));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_word = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	psi_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int cycle_count = 0;
	int coef_loads = 0;
	int phase_count = 0;
	bit ar_known [MAX_AR_DEF * MSIZE];
	bit ma_known [MAX_MA_DEF * MSIZE];

	varma_impulse_response_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("varma_impulse_response_top test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_word(rsp_word);
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rsp_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
		end
	end

	function automatic int rand_coef();
		case ($urandom_range(3))
		0: return $urandom;
		1: return int'($urandom_range(32'h3_0000)) - 32'h1_8000;
		2: return $urandom_range(1) ? Q16_MAX : Q16_MIN;
		default: return int'($urandom_range(32'h1_FFFF)) - 32'h1_0000;
		endcase
	endfunction

	function automatic req_t control_word(op_t op);
		req_t w;
		w.opcode = op;
		w.coef_lag = 4'($urandom_range(15));
		w.coef_row = 3'($urandom_range(7));
		w.coef_col = 3'($urandom_range(7));
		w.coef_value = $urandom;
		return w;
	endfunction

	task automatic drop_valid();
		req_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_word(req_t w);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_word <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_word(w);
		@(negedge clk);
	endtask

	task automatic load_coef(op_t op, int lag, int row, int col, int value);
		req_t w;
		w.opcode = op;
		w.coef_lag = lag[3:0];
		w.coef_row = row[2:0];
		w.coef_col = col[2:0];
		w.coef_value = value;
		if (lag >= 1 && lag <= MAX_AR_DEF) begin
			if (op == OP_WR_AR)
				ar_known[(lag - 1) * MSIZE + row * MAX_DIM_DEF + col] = 1'b1;
			else
				ma_known[(lag - 1) * MSIZE + row * MAX_DIM_DEF + col] = 1'b1;
		end
		coef_loads++;
		send_word(w);
	endtask

	task automatic fill_coefs();
		int i, r, c;
		for (i = 0; i < sb.ar_order; i++)
			for (r = 0; r < sb.dim; r++)
				for (c = 0; c < sb.dim; c++)
					if (!ar_known[i * MSIZE + r * MAX_DIM_DEF + c])
						load_coef(OP_WR_AR, i + 1, r, c, rand_coef());
		for (i = 0; i < sb.ma_order; i++)
			for (r = 0; r < sb.dim; r++)
				for (c = 0; c < sb.dim; c++)
					if (!ma_known[i * MSIZE + r * MAX_DIM_DEF + c])
						load_coef(OP_WR_MA, i + 1, r, c, rand_coef());
	endtask

	task automatic send_random_item();
		int pick, lag;
		pick = $urandom_range(99);
		if (pick < 50) begin
			send_word(control_word(OP_EMIT));
		end else if (pick < 58) begin
			send_word(control_word(OP_RESTART));
		end else begin
			if ($urandom_range(9) == 0) begin
				lag = $urandom_range(8, 15);
				if (lag == 8)
					lag = 0;
			end else begin
				lag = $urandom_range(1, 8);
			end
			load_coef((pick < 79) ? OP_WR_AR : OP_WR_MA, lag, $urandom_range(7),
				$urandom_range(7), rand_coef());
		end
	endtask

	task automatic apb_access(reg_idx_t idx, logic [31:0] value);
		logic [31:0] got;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		if (got !== value)
			sb.report($sformatf("register %s read back %h, wrote %h", idx.name(), got, value));
		sb.set_reg(idx, value);
	endtask

	task automatic configure(int p, int q, int d, int ml);
		drop_valid();
		apb_access(REG_AR_ORDER, p);
		apb_access(REG_MA_ORDER, q);
		apb_access(REG_DIM, d);
		apb_access(REG_MAX_LAG, ml);
	endtask

	task automatic settle();
		drop_valid();
		while (sb.pending() != 0) @(negedge clk);
		repeat (72 + sb.dim * sb.dim * (sb.ar_order * sb.dim + 5)) @(negedge clk);
	endtask

	task automatic run_phase(int k);
		int p, q, d, ml, n, i;
		p = $urandom_range(3);
		q = $urandom_range(3);
		d = $urandom_range(1, 3);
		ml = $urandom_range(15);
		n = 12;
		case (k)
		0: begin
			p = 0;
			q = 0;
		end
		2: begin
			d = 8;
			p = 1;
			q = 0;
			ml = $urandom_range(2, 5);
			n = 6;
		end
		3: ml = 0;
		5: begin
			d = 1;
			p = 8;
			q = 8;
			ml = 40;
		end
		6: begin
			d = 2;
			p = 2;
			q = 1;
			ml = 60;
		end
		9: begin
			d = 1;
			p = 1;
			q = 0;
			ml = 1023;
		end
		default: ;
		endcase
		case (k % 4)
		0: begin
			send_idle_pct = 0;
			stall_pct = 0;
		end
		1: begin
			send_idle_pct = 56;
			stall_pct = 0;
		end
		2: begin
			send_idle_pct = 0;
			stall_pct = 56;
		end
		default: begin
			send_idle_pct = 8;
			stall_pct = 8;
		end
		endcase
		settle();
		configure(p, q, d, ml);
		fill_coefs();
		if (k == 9 || $urandom_range(1))
			send_word(control_word(OP_RESTART));
		if (k == 6)
			hold_cycles = 2500;
		if (k == 9) begin
			repeat (20) send_word(control_word(OP_EMIT));
		end else begin
			for (i = 0; i < n; i++) begin
				if (k == 7 && i == n / 2) begin
					drop_valid();
					while (sb.pending() != 0) @(negedge clk);
				end
				send_random_item();
			end
		end
		phase_count++;
	endtask

	initial begin
		int r, c;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(control_word(OP_EMIT));
		send_word(control_word(OP_EMIT));
		send_word(control_word(OP_RESTART));
		load_coef(OP_WR_AR, 0, 0, 0, 32'h0001_2345);
		load_coef(OP_WR_MA, 9, 7, 7, Q16_MIN);
		load_coef(OP_WR_AR, 15, 3, 5, Q16_MAX);
		settle();
		configure(1, 1, 2, 3);
		for (r = 0; r < 2; r++)
			for (c = 0; c < 2; c++) begin
				load_coef(OP_WR_AR, 1, r, c, (r == c) ? Q16_MAX : Q16_MIN);
				load_coef(OP_WR_MA, 1, r, c, (r == c) ? Q16_MAX : 32'sh0000_8000);
			end
		repeat (5) send_word(control_word(OP_EMIT));
		send_word(control_word(OP_RESTART));
		send_word(control_word(OP_EMIT));
		phase_count++;

		for (int k = 0; k < 14; k++)
			run_phase(k);

		settle();
		$display("Covered %0d phases, %0d coefficient loads and %0d emitted lags.",
			phase_count, coef_loads, sb.lags_done);
		$display("Compared %0d response words, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("varma_impulse_response_top test passed");
		else
			$display("varma_impulse_response_top test failed");
		$finish;
	end
endmodule

>>> varma_impulse_response_top.f
src/vir_pkg.sv
src/vir_regs.sv
src/vir_mac.sv
src/vir_core.sv
src/varma_impulse_response_top.sv
sim/testbench.sv
